@@ rtl/circular_fifo_queue_macros.svh @@
// ----------------------------------------------------------------------------
// circular_fifo_queue_macros.svh
// Assertion macros used by the queue RTL.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_FIFO_QUEUE_MACROS_SVH
`define CIRCULAR_FIFO_QUEUE_MACROS_SVH

// check a condition at every clock edge outside reset
`define CFQ_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("cfq assertion failed");

// check a condition in the cycle after a trigger
`define CFQ_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("cfq assertion failed");

`endif

@@ rtl/cfq_pkg.sv @@
// ----------------------------------------------------------------------------
// cfq_pkg
// Types and codes for the circular FIFO queue.
// ----------------------------------------------------------------------------
package cfq_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_PEEK = 2'd2,
        OP_DISP = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_DISP = 3'b100
    } t_state;

endpackage

@@ rtl/cfq_ram.sv @@
// ----------------------------------------------------------------------------
// cfq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/circular_fifo_queue.sv @@
// ----------------------------------------------------------------------------
// circular_fifo_queue
// Ring-buffer FIFO of DEPTH signed words with enqueue, dequeue, peek and
// display operations, driven by a small sequencer around one RAM read port.
//
//   channel   handshake          payload                    direction
//   command   i_start / o_busy   i_op, i_value              in
//   result    o_valid (strobe)   o_status, o_data, o_last   out
//
// Enqueue and every error result are registered at the accepting edge, so the
// result beat shows in the cycle after it. Dequeue and peek pass through the
// registered read of the entry RAM, then the result register. Display makes
// one RAM read per entry, reads overlapped with result beats.
// Reset is synchronous, active low; the queue comes up empty.
// Result beats cannot be stalled; o_busy is high while a read is in flight.
// ----------------------------------------------------------------------------
`include "circular_fifo_queue_macros.svh"

module circular_fifo_queue #(
    parameter int DEPTH = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  cfq_pkg::t_op                    i_op,
    input  logic signed [cfq_pkg::DATA_W-1:0] i_value,
    output logic                            o_valid,
    output cfq_pkg::t_status                o_status,
    output logic signed [cfq_pkg::DATA_W-1:0] o_data,
    output logic                            o_last
);

    import cfq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_state                   r_state,  n_state;
    logic [AW-1:0]            r_head,   n_head;
    logic [AW-1:0]            r_tail,   n_tail;
    logic [CW-1:0]            r_count,  n_count;
    logic [AW-1:0]            r_idx,    n_idx;
    logic [CW-1:0]            r_left,   n_left;
    logic                     r_valid,  n_valid;
    t_status                  r_status, n_status;
    logic signed [DATA_W-1:0] r_data,   n_data;
    logic                     r_last,   n_last;

    logic              ram_we;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    logic              full;
    logic              empty;

    function automatic logic [AW-1:0] f_adv(input logic [AW-1:0] p);
        if (p == AW'(DEPTH - 1)) begin
            return '0;
        end
        return p + AW'(1);
    endfunction

    assign full  = (r_count == CW'(DEPTH));
    assign empty = (r_count == '0);

    cfq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (i_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_idx     = r_idx;
        n_left    = r_left;
        n_valid   = 1'b0;
        n_status  = r_status;
        n_data    = r_data;
        n_last    = r_last;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = r_head;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_op)
                        OP_ENQ: begin
                            n_valid = 1'b1;
                            n_last  = 1'b1;
                            if (full) begin
                                n_status = ST_FULL;
                                n_data   = '0;
                            end else begin
                                ram_we   = 1'b1;
                                n_tail   = f_adv(r_tail);
                                n_count  = r_count + CW'(1);
                                n_status = ST_OK;
                                n_data   = i_value;
                            end
                        end
                        OP_DEQ, OP_PEEK: begin
                            if (empty) begin
                                n_valid  = 1'b1;
                                n_last   = 1'b1;
                                n_status = ST_EMPTY;
                                n_data   = '0;
                            end else begin
                                ram_re  = 1'b1;
                                n_state = S_READ;
                                if (i_op == OP_DEQ) begin
                                    n_head  = f_adv(r_head);
                                    n_count = r_count - CW'(1);
                                end
                            end
                        end
                        OP_DISP: begin
                            if (empty) begin
                                n_valid  = 1'b1;
                                n_last   = 1'b1;
                                n_status = ST_EMPTY;
                                n_data   = '0;
                            end else begin
                                ram_re  = 1'b1;
                                n_idx   = f_adv(r_head);
                                n_left  = r_count;
                                n_state = S_DISP;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_valid  = 1'b1;
                n_last   = 1'b1;
                n_status = ST_OK;
                n_data   = ram_rdata;
                n_state  = S_IDLE;
            end
            S_DISP: begin
                n_valid  = 1'b1;
                n_status = ST_OK;
                n_data   = ram_rdata;
                n_last   = (r_left == CW'(1));
                if (r_left == CW'(1)) begin
                    n_state = S_IDLE;
                end else begin
                    // fetch the next entry while this one goes out
                    ram_re    = 1'b1;
                    ram_raddr = r_idx;
                    n_idx     = f_adv(r_idx);
                    n_left    = r_left - CW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_idx   <= '0;
            r_left  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_left  <= n_left;
            r_valid <= n_valid;
        end
        r_status <= n_status;
        r_data   <= n_data;
        r_last   <= n_last;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_data   = r_data;
    assign o_last   = r_last;

    `CFQ_ASSERT_ALWAYS(a_count_range, r_count <= CW'(DEPTH))
    `CFQ_ASSERT_ALWAYS(a_ptr_meet, (r_count != '0 && r_count != CW'(DEPTH)) || r_head == r_tail)
    `CFQ_ASSERT_ALWAYS(a_disp_left, r_state != S_DISP || r_left != '0)
    `CFQ_ASSERT_NEXT(a_accept_resp, i_start && !o_busy, o_valid || o_busy)
    `CFQ_ASSERT_ALWAYS(a_err_beat, !o_valid || o_status == ST_OK || (o_last && o_data == '0))

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for circular_fifo_queue. A directed sequence hits the
// empty and full queue, the extreme data words and every operation, then a
// random phase alternates fill- and drain-biased command mixes with bursty
// issue. Every result beat is checked against a shadow ring buffer.
// ----------------------------------------------------------------------------

module testbench;

    import cfq_pkg::*;

    localparam int DEPTH          = 8;
    localparam int WATCHDOG_LIMIT = 1000;

    class queue_tracker;

        typedef struct packed {
            cfq_pkg::t_status   status;
            logic signed [31:0] data;
            logic               last;
        } t_beat;

        logic signed [31:0] slots [DEPTH];
        int unsigned        head;
        int unsigned        tail;
        int unsigned        count;
        t_beat              awaited [$];
        int                 mismatches;

        function new();
            head       = 0;
            tail       = 0;
            count      = 0;
            mismatches = 0;
        endfunction

        function void push_beat(cfq_pkg::t_status status, logic signed [31:0] data,
                                logic last);
            t_beat b;
            b.status = status;
            b.data   = data;
            b.last   = last;
            awaited.push_back(b);
        endfunction

        function void note_command(cfq_pkg::t_op op, logic signed [31:0] value);
            int unsigned idx;
            case (op)
                cfq_pkg::OP_ENQ: begin
                    if (count == DEPTH) begin
                        push_beat(cfq_pkg::ST_FULL, '0, 1'b1);
                    end else begin
                        slots[tail] = value;
                        tail = (tail + 1) % DEPTH;
                        count++;
                        push_beat(cfq_pkg::ST_OK, value, 1'b1);
                    end
                end
                cfq_pkg::OP_DEQ: begin
                    if (count == 0) begin
                        push_beat(cfq_pkg::ST_EMPTY, '0, 1'b1);
                    end else begin
                        push_beat(cfq_pkg::ST_OK, slots[head], 1'b1);
                        head = (head + 1) % DEPTH;
                        count--;
                    end
                end
                cfq_pkg::OP_PEEK: begin
                    if (count == 0) begin
                        push_beat(cfq_pkg::ST_EMPTY, '0, 1'b1);
                    end else begin
                        push_beat(cfq_pkg::ST_OK, slots[head], 1'b1);
                    end
                end
                default: begin
                    if (count == 0) begin
                        push_beat(cfq_pkg::ST_EMPTY, '0, 1'b1);
                    end else begin
                        idx = head;
                        for (int unsigned n = 0; n < count; n++) begin
                            push_beat(cfq_pkg::ST_OK, slots[idx], (n + 1 == count));
                            idx = (idx + 1) % DEPTH;
                        end
                    end
                end
            endcase
        endfunction

        task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
            $display("mismatch on %s: got %h, want %h", field, got, want);
            mismatches++;
        endtask

        task check_beat(cfq_pkg::t_status status, logic signed [31:0] data, logic last);
            t_beat want;
            if (awaited.size() == 0) begin
                report_mismatch("unexpected beat data", data, '0);
            end else begin
                want = awaited.pop_front();
                if (status !== want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
                if (data !== want.data)
                    report_mismatch("data", data, want.data);
                if (last !== want.last)
                    report_mismatch("last", 32'(last), 32'(want.last));
            end
        endtask

        function int pending();
            return awaited.size();
        endfunction

    endclass

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    t_op                i_op    = OP_PEEK;
    logic signed [31:0] i_value = '0;
    logic               o_busy;
    logic               o_valid;
    t_status            o_status;
    logic signed [31:0] o_data;
    logic               o_last;

    int idle_cycles = 0;

    queue_tracker tracker;

    circular_fifo_queue #(
        .DEPTH (DEPTH)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .o_busy   (o_busy),
        .i_op     (i_op),
        .i_value  (i_value),
        .o_valid  (o_valid),
        .o_status (o_status),
        .o_data   (o_data),
        .o_last   (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && o_busy === 1'b0)
                tracker.note_command(i_op, i_value);
            if (o_valid === 1'b1)
                tracker.check_beat(o_status, o_data, o_last);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_start && o_busy === 1'b0) || o_valid === 1'b1)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // hold the command until the block takes it, then idle for the given gap
    task send_command(input t_op op, input logic signed [31:0] value, input int gap);
        i_op    <= op;
        i_value <= value;
        i_start <= 1'b1;
        @(posedge i_clk);
        while (o_busy !== 1'b0) @(posedge i_clk);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task wait_drained();
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    function logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic signed [31:0] fill_words [9];
        int                 burst_left;
        int                 gap;
        int                 roll;
        logic               fill_mode;
        t_op                op;

        tracker    = new();
        fill_words = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                       32'haaaa_aaaa, 32'h5555_5555, 32'h0000_0001, 32'h8000_0001,
                       32'h1234_5678};
        burst_left = 0;
        fill_mode  = 1'b1;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_command(OP_PEEK, 32'h7fff_ffff, 0);
        send_command(OP_DEQ, 32'h8000_0000, 0);
        send_command(OP_DISP, 32'hffff_ffff, 1);
        for (int i = 0; i < 9; i++)
            send_command(OP_ENQ, fill_words[i], i % 3);
        send_command(OP_DISP, $urandom, 0);
        send_command(OP_PEEK, $urandom, 2);
        for (int i = 0; i < 8; i++)
            send_command(OP_DEQ, $urandom, i % 2);
        send_command(OP_ENQ, 32'h7fff_fffe, 0);
        send_command(OP_DISP, $urandom, 1);
        wait_drained();

        for (int k = 0; k < 330; k++) begin
            if ($urandom_range(0, 15) == 0)
                fill_mode = ~fill_mode;
            roll = $urandom_range(0, 99);
            if (roll < (fill_mode ? 55 : 20))
                op = OP_ENQ;
            else if (roll < 75)
                op = OP_DEQ;
            else if (roll < 85)
                op = OP_PEEK;
            else
                op = OP_DISP;
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 8);
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                          : $urandom_range(1, 12);
            end else begin
                gap = 0;
            end
            burst_left--;
            send_command(op, pick_value(), gap);
            if (k == 165) begin
                i_start <= 1'b0;
                @(posedge i_clk);
                wait_drained();
            end
        end

        i_start <= 1'b0;
        @(posedge i_clk);
        wait_drained();
        repeat (12) @(posedge i_clk);

        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
